// ----- design/hsbr_pkg.sv -----
`default_nettype none

package hsbr_pkg;

    localparam int unsigned CHAR_W = 8;
    localparam int unsigned VAL_W  = 64;
    localparam int unsigned ACC_W  = VAL_W + 4;

    localparam int unsigned IN_DATA_W  = CHAR_W + VAL_W;
    localparam int unsigned OUT_BITS   = 2 + VAL_W + VAL_W;
    localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [2:0] {
        PH_LEAD    = 3'd0,
        PH_UNIT    = 3'd1,
        PH_SETLEAD = 3'd2,
        PH_FIRST   = 3'd3,
        PH_LAST    = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        ST_ABSENT = 2'd0,
        ST_IGNORE = 2'd1,
        ST_UNSAT  = 2'd2,
        ST_OK     = 2'd3
    } status_t;

    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
    localparam logic [CHAR_W-1:0] CH_EQUALS  = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_DASH    = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CASE_BIT   = 8'h20;

    localparam int unsigned UNIT_LEN = 5;
    localparam logic [2:0]  UNIT_POS_FULL = 3'd5;
    localparam logic [CHAR_W-1:0] UNIT_WORD [UNIT_LEN] =
        '{8'h62, 8'h79, 8'h74, 8'h65, 8'h73};

endpackage

`default_nettype wire

// ----- design/http_single_byte_range_parser_top.sv -----
// channel  dir  tdata (low bit up)                       tuser       tlast
// s_axis   in   char_in[7:0], total_size[71:8]           char_valid  end_of_header
// m_axis   out  status[1:0], first_byte[65:2],           -           -
//               last_byte[129:66], zero pad [135:130]
//
// one byte per cycle unless a final byte stalls; verdict then output register hold it
// stages: input register, byte consume and state update, verdict compare, output register
// reset clears the parser state and all valid flags; no clearing pass
// a stalled result holds back a final byte and every byte behind it in the input register
`default_nettype none

module http_single_byte_range_parser_top
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    input  wire logic [hsbr_pkg::IN_DATA_W-1:0]       s_axis_tdata,  // char_in, total_size
    input  wire logic                                 s_axis_tuser,  // char_valid
    input  wire logic                                 s_axis_tlast,
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    output logic [hsbr_pkg::OUT_DATA_W-1:0]           m_axis_tdata   // status, first_byte, last_byte
);

    localparam int unsigned CW = hsbr_pkg::CHAR_W;
    localparam int unsigned VW = hsbr_pkg::VAL_W;
    localparam int unsigned AW = hsbr_pkg::ACC_W;

    // input register
    logic          in_valid_reg;
    logic [CW-1:0] in_char_reg;
    logic          in_cvalid_reg;
    logic          in_last_reg;
    logic [VW-1:0] in_fs_reg;

    // parser state
    hsbr_pkg::phase_t phase_reg, phase_next;
    logic [2:0]    unit_pos_reg, unit_pos_next;
    logic          bad_reg, bad_next;
    logic          space_reg, space_next;
    logic          saw_reg, saw_next;
    logic [VW-1:0] first_val_reg, first_val_next;
    logic          first_has_reg, first_has_next;
    logic [VW-1:0] last_val_reg, last_val_next;
    logic          last_has_reg, last_has_next;

    // verdict stage snapshot
    logic          v_valid_reg;
    logic          v_saw_reg;
    logic          v_bad_reg;
    logic          v_first_has_reg;
    logic          v_last_has_reg;
    logic [VW-1:0] v_first_reg;
    logic [VW-1:0] v_last_reg;
    logic [VW-1:0] v_fs_reg;

    // output register
    logic              out_valid_reg;
    hsbr_pkg::status_t out_status_reg;
    logic [VW-1:0]     out_first_reg;
    logic [VW-1:0]     out_last_reg;

    logic s_accept;
    logic o_load;
    logic v_free;
    logic a_adv;

    logic          is_ows;
    logic          is_digit;
    logic [CW-1:0] lower_char;
    logic [3:0]    digit;
    logic [AW-1:0] first_acc;
    logic [AW-1:0] last_acc;
    logic          first_ovf;
    logic          last_ovf;

    hsbr_pkg::status_t status_calc;
    logic [VW-1:0]     fb_calc;
    logic [VW-1:0]     lb_calc;

    // handshake
    assign o_load        = v_valid_reg && (!out_valid_reg || m_axis_tready);
    assign v_free        = !v_valid_reg || o_load;
    assign a_adv         = in_valid_reg && (!in_last_reg || v_free);
    assign s_axis_tready = !in_valid_reg || a_adv;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (a_adv)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_char_reg   <= s_axis_tdata[CW-1:0];
            in_fs_reg     <= s_axis_tdata[CW+VW-1:CW];
            in_cvalid_reg <= s_axis_tuser;
            in_last_reg   <= s_axis_tlast;
        end
    end

    // byte classification and decimal accumulate
    assign is_ows     = (in_char_reg == hsbr_pkg::CH_SPACE) || (in_char_reg == hsbr_pkg::CH_TAB);
    assign is_digit   = (in_char_reg >= hsbr_pkg::CH_ZERO) && (in_char_reg <= hsbr_pkg::CH_NINE);
    assign lower_char = ((in_char_reg >= hsbr_pkg::CH_UPPER_A) &&
                         (in_char_reg <= hsbr_pkg::CH_UPPER_Z)) ?
                        (in_char_reg | hsbr_pkg::CASE_BIT) : in_char_reg;
    assign digit      = in_char_reg[3:0];
    assign first_acc  = ({4'b0, first_val_reg} << 3) + ({4'b0, first_val_reg} << 1) + AW'(digit);
    assign last_acc   = ({4'b0, last_val_reg} << 3) + ({4'b0, last_val_reg} << 1) + AW'(digit);
    assign first_ovf  = |first_acc[AW-1:VW];
    assign last_ovf   = |last_acc[AW-1:VW];

    // consume one byte
    always_comb
    begin
        logic             live;
        hsbr_pkg::phase_t ph;

        live           = in_cvalid_reg;
        ph             = phase_reg;
        phase_next     = phase_reg;
        unit_pos_next  = unit_pos_reg;
        bad_next       = bad_reg;
        space_next     = space_reg;
        saw_next       = saw_reg;
        first_val_next = first_val_reg;
        first_has_next = first_has_reg;
        last_val_next  = last_val_reg;
        last_has_next  = last_has_reg;

        if (live && (ph == hsbr_pkg::PH_LEAD))
        begin
            if (is_ows)
            begin
                live = 1'b0;
            end
            else
            begin
                saw_next   = 1'b1;
                ph         = hsbr_pkg::PH_UNIT;
                phase_next = hsbr_pkg::PH_UNIT;
            end
        end

        if (live && !bad_reg)
        begin
            unique case (ph)
                hsbr_pkg::PH_UNIT:
                begin
                    if (is_ows)
                    begin
                        space_next = 1'b1;
                    end
                    else if (in_char_reg == hsbr_pkg::CH_EQUALS)
                    begin
                        if (unit_pos_reg != hsbr_pkg::UNIT_POS_FULL)
                        begin
                            bad_next = 1'b1;
                        end
                        phase_next = hsbr_pkg::PH_SETLEAD;
                        space_next = 1'b0;
                    end
                    else if (space_reg || (unit_pos_reg >= hsbr_pkg::UNIT_POS_FULL))
                    begin
                        bad_next = 1'b1;
                    end
                    else if (lower_char != hsbr_pkg::UNIT_WORD[unit_pos_reg])
                    begin
                        bad_next = 1'b1;
                    end
                    else
                    begin
                        unit_pos_next = unit_pos_reg + 3'd1;
                    end
                end
                hsbr_pkg::PH_SETLEAD:
                begin
                    if (is_ows)
                    begin
                        phase_next = hsbr_pkg::PH_SETLEAD;
                    end
                    else if (in_char_reg == hsbr_pkg::CH_DASH)
                    begin
                        phase_next = hsbr_pkg::PH_LAST;
                    end
                    else if (is_digit)
                    begin
                        phase_next     = hsbr_pkg::PH_FIRST;
                        first_has_next = 1'b1;
                        if (first_ovf)
                        begin
                            bad_next = 1'b1;
                        end
                        else
                        begin
                            first_val_next = first_acc[VW-1:0];
                        end
                    end
                    else
                    begin
                        bad_next = 1'b1;
                    end
                end
                hsbr_pkg::PH_FIRST:
                begin
                    if (is_ows)
                    begin
                        space_next = 1'b1;
                    end
                    else if (space_reg)
                    begin
                        bad_next = 1'b1;
                    end
                    else if (in_char_reg == hsbr_pkg::CH_DASH)
                    begin
                        phase_next = hsbr_pkg::PH_LAST;
                    end
                    else if (is_digit)
                    begin
                        if (first_ovf)
                        begin
                            bad_next = 1'b1;
                        end
                        else
                        begin
                            first_val_next = first_acc[VW-1:0];
                        end
                    end
                    else
                    begin
                        bad_next = 1'b1;
                    end
                end
                hsbr_pkg::PH_LAST:
                begin
                    if (is_ows)
                    begin
                        space_next = 1'b1;
                    end
                    else if (space_reg || !is_digit)
                    begin
                        bad_next = 1'b1;
                    end
                    else
                    begin
                        last_has_next = 1'b1;
                        if (last_ovf)
                        begin
                            bad_next = 1'b1;
                        end
                        else
                        begin
                            last_val_next = last_acc[VW-1:0];
                        end
                    end
                end
                default:
                begin
                    bad_next = 1'b1;
                end
            endcase
        end
    end

    // parser state, cleared after each final byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= hsbr_pkg::PH_LEAD;
            unit_pos_reg  <= 3'd0;
            bad_reg       <= 1'b0;
            space_reg     <= 1'b0;
            saw_reg       <= 1'b0;
            first_val_reg <= '0;
            first_has_reg <= 1'b0;
            last_val_reg  <= '0;
            last_has_reg  <= 1'b0;
        end
        else if (a_adv)
        begin
            if (in_last_reg)
            begin
                phase_reg     <= hsbr_pkg::PH_LEAD;
                unit_pos_reg  <= 3'd0;
                bad_reg       <= 1'b0;
                space_reg     <= 1'b0;
                saw_reg       <= 1'b0;
                first_val_reg <= '0;
                first_has_reg <= 1'b0;
                last_val_reg  <= '0;
                last_has_reg  <= 1'b0;
            end
            else
            begin
                phase_reg     <= phase_next;
                unit_pos_reg  <= unit_pos_next;
                bad_reg       <= bad_next;
                space_reg     <= space_next;
                saw_reg       <= saw_next;
                first_val_reg <= first_val_next;
                first_has_reg <= first_has_next;
                last_val_reg  <= last_val_next;
                last_has_reg  <= last_has_next;
            end
        end
    end

    // verdict stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_valid_reg <= 1'b0;
        end
        else if (a_adv && in_last_reg)
        begin
            v_valid_reg <= 1'b1;
        end
        else if (o_load)
        begin
            v_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_adv && in_last_reg)
        begin
            v_saw_reg       <= saw_next;
            v_bad_reg       <= bad_next || (phase_next != hsbr_pkg::PH_LAST);
            v_first_has_reg <= first_has_next;
            v_last_has_reg  <= last_has_next;
            v_first_reg     <= first_val_next;
            v_last_reg      <= last_val_next;
            v_fs_reg        <= in_fs_reg;
        end
    end

    always_comb
    begin
        logic fs_zero;
        logic last_ge_fs;
        logic first_ge_fs;

        fs_zero     = (v_fs_reg == '0);
        last_ge_fs  = (v_last_reg >= v_fs_reg);
        first_ge_fs = (v_first_reg >= v_fs_reg);
        status_calc = hsbr_pkg::ST_IGNORE;
        fb_calc     = '0;
        lb_calc     = '0;

        if (!v_saw_reg)
        begin
            status_calc = hsbr_pkg::ST_ABSENT;
        end
        else if (v_bad_reg)
        begin
            status_calc = hsbr_pkg::ST_IGNORE;
        end
        else if (!v_first_has_reg)
        begin
            // suffix form
            if (!v_last_has_reg)
            begin
                status_calc = hsbr_pkg::ST_IGNORE;
            end
            else if (fs_zero || (v_last_reg == '0))
            begin
                status_calc = hsbr_pkg::ST_UNSAT;
            end
            else
            begin
                status_calc = hsbr_pkg::ST_OK;
                fb_calc     = last_ge_fs ? '0 : (v_fs_reg - v_last_reg);
                lb_calc     = v_fs_reg - VW'(1);
            end
        end
        else if (v_last_has_reg && (v_first_reg > v_last_reg))
        begin
            status_calc = hsbr_pkg::ST_IGNORE;
        end
        else if (fs_zero || first_ge_fs)
        begin
            status_calc = hsbr_pkg::ST_UNSAT;
        end
        else
        begin
            status_calc = hsbr_pkg::ST_OK;
            fb_calc     = v_first_reg;
            lb_calc     = (!v_last_has_reg || last_ge_fs) ? (v_fs_reg - VW'(1)) : v_last_reg;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (o_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (o_load)
        begin
            out_status_reg <= status_calc;
            out_first_reg  <= fb_calc;
            out_last_reg   <= lb_calc;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(hsbr_pkg::OUT_DATA_W - hsbr_pkg::OUT_BITS){1'b0}},
                            out_last_reg, out_first_reg, out_status_reg};

    // checks
    a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_status_reg != hsbr_pkg::ST_OK)
        |-> (out_first_reg == '0) && (out_last_reg == '0))
        else $error("offsets not zero on a non-ok verdict");

    a_ok_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_status_reg == hsbr_pkg::ST_OK) |-> (out_first_reg <= out_last_reg))
        else $error("ok verdict with first past last");

    a_lead_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == hsbr_pkg::PH_LEAD) |-> !saw_reg && !bad_reg && !first_has_reg)
        else $error("leading phase with content recorded");

    a_final_to_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        a_adv && in_last_reg |=> v_valid_reg && (phase_reg == hsbr_pkg::PH_LEAD))
        else $error("final byte did not reach the verdict stage");

    a_unit_pos: assert property (@(posedge clk) disable iff (!rst_n)
        unit_pos_reg <= hsbr_pkg::UNIT_POS_FULL)
        else $error("unit match position out of range");

endmodule

`default_nettype wire

// ----- verif/http_single_byte_range_parser_top_test.sv -----
`default_nettype none

module http_single_byte_range_parser_top_test;

    localparam int unsigned CHAR_W     = hsbr_pkg::CHAR_W;
    localparam int unsigned VAL_W      = hsbr_pkg::VAL_W;
    localparam int unsigned ACC_W      = hsbr_pkg::ACC_W;
    localparam int unsigned IN_DATA_W  = hsbr_pkg::IN_DATA_W;
    localparam int unsigned OUT_DATA_W = hsbr_pkg::OUT_DATA_W;

    localparam int unsigned ITEM_TARGET  = 1500;
    localparam int unsigned CALM_TAIL    = 150;
    localparam int unsigned STALL_LIMIT  = 400;
    localparam int unsigned DRAIN_CYCLES = 12;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [VAL_W-1:0]  ALL_ONES = '1;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              has_char;
        logic              eoh;
        logic [VAL_W-1:0]  fsize;
    } hdr_item_t;

    typedef struct packed {
        hsbr_pkg::status_t status;
        logic [VAL_W-1:0]  first_byte;
        logic [VAL_W-1:0]  last_byte;
    } range_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // char_in, total_size
    logic                  s_axis_tuser = 1'b0; // char_valid
    logic                  s_axis_tlast = 1'b0; // end_of_header
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // status, first_byte, last_byte

    hdr_item_t        pend_q[$];
    range_res_t       verdict_q[$];
    logic [CHAR_W-1:0] hdr_bytes[$];

    bit in_fire;
    bit out_fire;
    bit steady;
    int in_gap;
    int out_gap;
    int stall_cycles;
    int mismatch_cnt;

    // parser state kept by the testbench
    hsbr_pkg::phase_t hp_phase;
    logic [2:0]       hp_unit_pos;
    logic             hp_bad;
    logic             hp_space;
    logic             hp_content;
    logic [VAL_W-1:0] hp_first;
    logic             hp_first_dig;
    logic [VAL_W-1:0] hp_last;
    logic             hp_last_dig;

    http_single_byte_range_parser_top u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic bit is_blank(input logic [CHAR_W-1:0] c);
        return c == hsbr_pkg::CH_SPACE || c == hsbr_pkg::CH_TAB;
    endfunction

    function automatic bit is_numeral(input logic [CHAR_W-1:0] c);
        return c >= hsbr_pkg::CH_ZERO && c <= hsbr_pkg::CH_NINE;
    endfunction

    // msb set on overflow, accumulator then unchanged
    function automatic logic [VAL_W:0] times_ten_plus(input logic [VAL_W-1:0] acc,
                                                      input logic [CHAR_W-1:0] c);
        logic [ACC_W-1:0] wide;
        wide = {4'b0000, acc} * ACC_W'(10) + ACC_W'(c - hsbr_pkg::CH_ZERO);
        if (wide[ACC_W-1:VAL_W] != 0)
            return {1'b1, acc};
        return {1'b0, wide[VAL_W-1:0]};
    endfunction

    task automatic clear_parser();
        hp_phase     = hsbr_pkg::PH_LEAD;
        hp_unit_pos  = '0;
        hp_bad       = 1'b0;
        hp_space     = 1'b0;
        hp_content   = 1'b0;
        hp_first     = '0;
        hp_first_dig = 1'b0;
        hp_last      = '0;
        hp_last_dig  = 1'b0;
    endtask

    task automatic absorb_byte(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] lc;
        logic [VAL_W:0]    acc;
        lc = (c >= hsbr_pkg::CH_UPPER_A && c <= hsbr_pkg::CH_UPPER_Z) ?
             (c | hsbr_pkg::CASE_BIT) : c;
        if (hp_phase == hsbr_pkg::PH_LEAD && !is_blank(c))
        begin
            hp_content = 1'b1;
            hp_phase   = hsbr_pkg::PH_UNIT;
        end
        if (hp_phase != hsbr_pkg::PH_LEAD && !hp_bad)
        begin
            case (hp_phase)
                hsbr_pkg::PH_UNIT:
                begin
                    if (is_blank(c))
                        hp_space = 1'b1;
                    else if (c == hsbr_pkg::CH_EQUALS)
                    begin
                        if (hp_unit_pos != hsbr_pkg::UNIT_POS_FULL)
                            hp_bad = 1'b1;
                        hp_phase = hsbr_pkg::PH_SETLEAD;
                        hp_space = 1'b0;
                    end
                    else if (hp_space || hp_unit_pos >= hsbr_pkg::UNIT_POS_FULL ||
                             lc != hsbr_pkg::UNIT_WORD[hp_unit_pos])
                        hp_bad = 1'b1;
                    else
                        hp_unit_pos = hp_unit_pos + 3'd1;
                end
                hsbr_pkg::PH_SETLEAD:
                begin
                    if (is_blank(c))
                        hp_bad = hp_bad;
                    else if (c == hsbr_pkg::CH_DASH)
                        hp_phase = hsbr_pkg::PH_LAST;
                    else if (is_numeral(c))
                    begin
                        hp_phase     = hsbr_pkg::PH_FIRST;
                        hp_first_dig = 1'b1;
                        acc          = times_ten_plus(hp_first, c);
                        hp_first     = acc[VAL_W-1:0];
                        hp_bad       = acc[VAL_W];
                    end
                    else
                        hp_bad = 1'b1;
                end
                hsbr_pkg::PH_FIRST:
                begin
                    if (is_blank(c))
                        hp_space = 1'b1;
                    else if (hp_space)
                        hp_bad = 1'b1;
                    else if (c == hsbr_pkg::CH_DASH)
                        hp_phase = hsbr_pkg::PH_LAST;
                    else if (is_numeral(c))
                    begin
                        acc      = times_ten_plus(hp_first, c);
                        hp_first = acc[VAL_W-1:0];
                        hp_bad   = acc[VAL_W];
                    end
                    else
                        hp_bad = 1'b1;
                end
                hsbr_pkg::PH_LAST:
                begin
                    if (is_blank(c))
                        hp_space = 1'b1;
                    else if (hp_space || !is_numeral(c))
                        hp_bad = 1'b1;
                    else
                    begin
                        hp_last_dig = 1'b1;
                        acc         = times_ten_plus(hp_last, c);
                        hp_last     = acc[VAL_W-1:0];
                        hp_bad      = acc[VAL_W];
                    end
                end
                default:
                    hp_bad = 1'b1;
            endcase
        end
    endtask

    function automatic range_res_t range_verdict(input logic [VAL_W-1:0] fsize);
        range_res_t r;
        r.status     = hsbr_pkg::ST_ABSENT;
        r.first_byte = '0;
        r.last_byte  = '0;
        if (!hp_content)
            return r;
        r.status = hsbr_pkg::ST_IGNORE;
        if (hp_bad || hp_phase != hsbr_pkg::PH_LAST)
            return r;
        if (!hp_first_dig)
        begin
            // suffix form
            if (!hp_last_dig)
                return r;
            r.status = hsbr_pkg::ST_UNSAT;
            if (fsize == 0 || hp_last == 0)
                return r;
            r.status     = hsbr_pkg::ST_OK;
            r.first_byte = (hp_last >= fsize) ? '0 : fsize - hp_last;
            r.last_byte  = fsize - 1;
            return r;
        end
        if (hp_last_dig && hp_first > hp_last)
            return r;
        r.status = hsbr_pkg::ST_UNSAT;
        if (fsize == 0 || hp_first >= fsize)
            return r;
        r.status     = hsbr_pkg::ST_OK;
        r.first_byte = hp_first;
        r.last_byte  = (!hp_last_dig || hp_last >= fsize) ? fsize - 1 : hp_last;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
                                   input logic [VAL_W-1:0] want);
        $display("mismatch on %s: got %0d, want %0d", what, got, want);
        mismatch_cnt++;
    endtask

    task automatic check_result(input logic [OUT_DATA_W-1:0] d);
        range_res_t want;
        if (verdict_q.size() == 0)
            report_mismatch("result with nothing pending", d[1:0], 0);
        else
        begin
            want = verdict_q.pop_front();
            if (d[1:0] !== want.status)
                report_mismatch("status", d[1:0], want.status);
            if (d[2+VAL_W-1:2] !== want.first_byte)
                report_mismatch("first_byte", d[2+VAL_W-1:2], want.first_byte);
            if (d[2+2*VAL_W-1:2+VAL_W] !== want.last_byte)
                report_mismatch("last_byte", d[2+2*VAL_W-1:2+VAL_W], want.last_byte);
        end
    endtask

    // header building

    function automatic logic [VAL_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic push_str(input string txt);
        for (int i = 0; i < txt.len(); i++)
            hdr_bytes.insert(hdr_bytes.size(), txt[i]);
    endtask

    task automatic push_num(input logic [VAL_W-1:0] v);
        logic [CHAR_W-1:0] digs[$];
        do
        begin
            digs.push_front(hsbr_pkg::CH_ZERO + 8'(v % 10));
            v = v / 10;
        end
        while (v != 0);
        foreach (digs[i])
            hdr_bytes.insert(hdr_bytes.size(), digs[i]);
    endtask

    task automatic push_blanks(input int n);
        for (int i = 0; i < n; i++)
            hdr_bytes.insert(hdr_bytes.size(),
                             $urandom_range(0, 1) ? hsbr_pkg::CH_SPACE : hsbr_pkg::CH_TAB);
    endtask

    task automatic push_value(input logic [VAL_W-1:0] v);
        case ($urandom_range(0, 11))
            0:
            begin
                // just past 2^64-1
                push_str("1844674407370955161");
                hdr_bytes.insert(hdr_bytes.size(),
                                 hsbr_pkg::CH_ZERO + 8'($urandom_range(6, 9)));
            end
            1:
            begin
                push_str("00");
                push_num(v);
            end
            default:
                push_num(v);
        endcase
    endtask

    function automatic logic [CHAR_W-1:0] pick_stray();
        case ($urandom_range(0, 7))
            0: return CH_COMMA;
            1: return hsbr_pkg::CH_DASH;
            2: return hsbr_pkg::CH_SPACE;
            3: return hsbr_pkg::CH_TAB;
            4: return hsbr_pkg::CH_EQUALS;
            5: return hsbr_pkg::CH_ZERO + 8'($urandom_range(0, 9));
            6: return hsbr_pkg::UNIT_WORD[$urandom_range(0, hsbr_pkg::UNIT_LEN-1)];
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [VAL_W-1:0] pick_size();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return rand64();
            2: return ALL_ONES;
            default: return VAL_W'($urandom_range(1, 5000));
        endcase
    endfunction

    function automatic logic [VAL_W-1:0] pick_pos(input logic [VAL_W-1:0] fsize);
        case ($urandom_range(0, 7))
            0: return '0;
            1: return fsize - 1;
            2: return fsize;
            3: return fsize + 1;
            4: return (fsize == 0) ? '0 : rand64() % fsize;
            5: return rand64();
            6: return VAL_W'($urandom_range(0, 9999));
            default: return ALL_ONES;
        endcase
    endfunction

    task automatic emit_header(input logic [VAL_W-1:0] fsize, input bit noisy,
                               input bit tail_gap);
        hdr_item_t it;
        int        n;
        bit        end_empty;
        n = hdr_bytes.size();
        end_empty = (n == 0) || tail_gap || (noisy && $urandom_range(0, 9) == 0);
        for (int i = 0; i < n; i++)
        begin
            if (noisy && $urandom_range(0, 15) == 0)
            begin
                it.ch       = 8'($urandom_range(0, 255));
                it.has_char = 1'b0;
                it.eoh      = 1'b0;
                it.fsize    = rand64();
                pend_q.insert(pend_q.size(), it);
            end
            it.ch       = hdr_bytes[i];
            it.has_char = 1'b1;
            it.eoh      = (i == n - 1) && !end_empty;
            it.fsize    = it.eoh ? fsize : rand64();
            pend_q.insert(pend_q.size(), it);
        end
        if (end_empty)
        begin
            it.ch       = 8'($urandom_range(0, 255));
            it.has_char = 1'b0;
            it.eoh      = 1'b1;
            it.fsize    = fsize;
            pend_q.insert(pend_q.size(), it);
        end
        hdr_bytes.delete();
    endtask

    task automatic directed_case(input string txt, input logic [VAL_W-1:0] fsize);
        push_str(txt);
        emit_header(fsize, 1'b0, 1'b0);
    endtask

    task automatic load_directed();
        directed_case("", 64'd100);
        directed_case("  \t ", 64'd100);
        directed_case("bytes=0-499", 64'd1000);
        directed_case(" \tByTeS \t= \t500-  ", 64'd1000);
        directed_case("bytes=-200", 64'd1000);
        directed_case("BYTES=-2000", 64'd1000);
        directed_case("bytes=-0", 64'd1000);
        directed_case("bytes=0-0", 64'd0);
        directed_case("bytes=1000-", 64'd1000);
        directed_case("bytes=5-3", 64'd1000);
        directed_case("bytes=0-1,5-6", 64'd1000);
        directed_case("bytes=1-2-3", 64'd1000);
        directed_case("bytes=-", 64'd1000);
        directed_case("bytes=", 64'd1000);
        directed_case("byte=0-1", 64'd1000);
        directed_case("by tes=0-1", 64'd1000);
        directed_case("bytes 0-1", 64'd1000);
        directed_case("bytes=1 2-3", 64'd1000);
        directed_case("bytes=0 -5", 64'd1000);
        directed_case("bytes=18446744073709551614-18446744073709551615", ALL_ONES);
        directed_case("bytes=-18446744073709551615", ALL_ONES);
        directed_case("bytes=18446744073709551616-", ALL_ONES);
        directed_case("bytes=0-99999999999999999999", ALL_ONES);
        push_str("bytes=");
        hdr_bytes.insert(hdr_bytes.size(), 8'hFF);
        emit_header(64'd10, 1'b0, 1'b0);
        // verdict on an item without a byte
        push_str("bytes= 0-9 ");
        emit_header(64'd5, 1'b0, 1'b1);
    endtask

    task automatic load_random_header();
        logic [VAL_W-1:0] fsize;
        logic [VAL_W-1:0] a;
        logic [VAL_W-1:0] b;
        logic [VAL_W-1:0] t;
        int               pos;
        int               n;
        fsize = pick_size();
        case ($urandom_range(0, 19))
            0:
                hdr_bytes.delete();
            1, 2:
            begin
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++)
                    hdr_bytes.insert(hdr_bytes.size(), pick_stray());
            end
            default:
            begin
                push_blanks($urandom_range(0, 2));
                for (int i = 0; i < hsbr_pkg::UNIT_LEN; i++)
                    hdr_bytes.insert(hdr_bytes.size(),
                                     $urandom_range(0, 1) ? hsbr_pkg::UNIT_WORD[i]
                                     : hsbr_pkg::UNIT_WORD[i] & ~hsbr_pkg::CASE_BIT);
                push_blanks($urandom_range(0, 1));
                hdr_bytes.insert(hdr_bytes.size(), hsbr_pkg::CH_EQUALS);
                push_blanks($urandom_range(0, 1));
                a = pick_pos(fsize);
                b = pick_pos(fsize);
                if (a > b && $urandom_range(0, 3) != 0)
                begin
                    t = a;
                    a = b;
                    b = t;
                end
                case ($urandom_range(0, 2))
                    0:
                    begin
                        push_value(a);
                        hdr_bytes.insert(hdr_bytes.size(), hsbr_pkg::CH_DASH);
                        push_value(b);
                    end
                    1:
                    begin
                        push_value(a);
                        hdr_bytes.insert(hdr_bytes.size(), hsbr_pkg::CH_DASH);
                    end
                    default:
                    begin
                        hdr_bytes.insert(hdr_bytes.size(), hsbr_pkg::CH_DASH);
                        push_value(b);
                    end
                endcase
                push_blanks($urandom_range(0, 2));
                // break the spec now and then
                if ($urandom_range(0, 3) == 0)
                begin
                    pos = $urandom_range(0, hdr_bytes.size() - 1);
                    case ($urandom_range(0, 2))
                        0: hdr_bytes[pos] = 8'($urandom_range(0, 255));
                        1: hdr_bytes.insert(pos, pick_stray());
                        default: hdr_bytes.delete(pos);
                    endcase
                end
            end
        endcase
        emit_header(fsize, 1'b1, 1'b0);
    endtask

    // sender
    always @(negedge clk)
    begin
        hdr_item_t it;
        if (rst_n && (!s_axis_tvalid || in_fire))
        begin
            if (in_gap > 0)
            begin
                in_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (!steady && $urandom_range(0, 7) == 0)
            begin
                in_gap = $urandom_range(0, 5);
                s_axis_tvalid <= 1'b0;
            end
            else if (pend_q.size() > 0)
            begin
                it = pend_q.pop_front();
                s_axis_tdata  <= {it.fsize, it.ch};
                s_axis_tuser  <= it.has_char;
                s_axis_tlast  <= it.eoh;
                s_axis_tvalid <= 1'b1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // receiver back-pressure
    always @(negedge clk)
    begin
        if (out_gap > 0)
        begin
            out_gap--;
            m_axis_tready <= 1'b0;
        end
        else if (!steady && $urandom_range(0, 5) == 0)
        begin
            out_gap = $urandom_range(0, 5);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // monitor, prediction and watchdog
    always @(posedge clk)
    begin
        in_fire  = rst_n && s_axis_tvalid && s_axis_tready;
        out_fire = rst_n && m_axis_tvalid && m_axis_tready;
        steady   = pend_q.size() < CALM_TAIL;
        if (in_fire)
        begin
            if (s_axis_tuser)
                absorb_byte(s_axis_tdata[CHAR_W-1:0]);
            if (s_axis_tlast)
            begin
                verdict_q.insert(verdict_q.size(),
                                 range_verdict(s_axis_tdata[IN_DATA_W-1:CHAR_W]));
                clear_parser();
            end
        end
        if (out_fire)
            check_result(m_axis_tdata);
        if (!rst_n || in_fire || out_fire)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        clear_parser();
        load_directed();
        while (pend_q.size() < ITEM_TARGET)
            load_random_header();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (pend_q.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        @(negedge clk);
        while (verdict_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_cnt == 0 && verdict_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
